[hw/rtl/rse_pkg.sv]
`default_nettype none

package rse_pkg;

    // Cell count of the parity chain, and the legal range of the parity count
    localparam int MAX_PARITY_DEF = 32;
    localparam int EC_MIN         = 7;
    localparam int EC_MAX         = 30;
    localparam int EC_WIDTH       = 5;
    localparam logic [EC_WIDTH-1:0] EC_RESET = 5'd10;

    // Low byte of the field polynomial x^8+x^4+x^3+x^2+1
    localparam logic [7:0] GF_POLY_LO = 8'h1D;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_DERIVE,
        S_RUN
    } t_state;

    // Control broadcast from the sequencer to every cell of the chain
    typedef struct packed {
        logic       clear;
        logic       gen_step;
        logic       rem_step;
        logic       rem_zero;
        logic       par_load;
        logic       par_shift;
        logic [7:0] fb;
        logic [7:0] root;
    } t_cell_ctrl;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LO : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] p;
        x = a;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p = p ^ x;
            end
            x = gf_xtime(x);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rse_data_if.sv]
`default_nettype none

interface rse_data_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_data;

    modport source (output valid, output data_byte, output last_data, input ready);
    modport sink (input valid, input data_byte, input last_data, output ready);
endinterface

`default_nettype wire

[hw/rtl/rse_parity_if.sv]
`default_nettype none

interface rse_parity_if;
    logic       valid;
    logic       ready;
    logic [7:0] parity_byte;
    logic       last_parity;

    modport source (output valid, output parity_byte, output last_parity, input ready);
    modport sink (input valid, input parity_byte, input last_parity, output ready);
endinterface

`default_nettype wire

[hw/rtl/rse_cfg_if.sv]
`default_nettype none

interface rse_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] ec_count;

    modport source (output valid, output ec_count, input ready);
    modport sink (input valid, input ec_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/rse_cell.sv]
`default_nettype none

// One stage of the parity chain: a remainder byte, a generator coefficient
// and a byte of the parity shift-out line.
module rse_cell (
    input  wire                      i_clk,
    input  wire rse_pkg::t_cell_ctrl i_ctrl,
    input  wire  [7:0]               i_rem_lo,
    input  wire  [7:0]               i_gen_hi,
    input  wire  [7:0]               i_par_lo,
    output logic [7:0]               o_rem,
    output logic [7:0]               o_gen,
    output logic [7:0]               o_par
);

    logic [7:0] r_rem;
    logic [7:0] r_gen;
    logic [7:0] r_par;
    logic [7:0] n_rem;
    logic [7:0] n_gen;

    assign n_rem = i_rem_lo ^ rse_pkg::gf_mul(i_ctrl.fb, r_gen);
    // Multiply the partial generator by (x + root): take the upper neighbour
    assign n_gen = r_gen ^ rse_pkg::gf_mul(i_ctrl.root, i_gen_hi);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_rem <= 8'h00;
            r_gen <= 8'h00;
        end else begin
            if (i_ctrl.gen_step) begin
                r_gen <= n_gen;
            end
            if (i_ctrl.rem_step) begin
                r_rem <= i_ctrl.rem_zero ? 8'h00 : n_rem;
            end
        end
        if (i_ctrl.par_load) begin
            r_par <= n_rem;
        end else if (i_ctrl.par_shift) begin
            r_par <= i_par_lo;
        end
    end

    assign o_rem = r_rem;
    assign o_gen = r_gen;
    assign o_par = r_par;

endmodule

`default_nettype wire

[hw/rtl/qr_reed_solomon_ecc_encoder.sv]
// Systematic Reed-Solomon parity encoder, GF(256), polynomial 0x11D, roots alpha^0..n-1.
// i_data : data codewords, one per transaction; last_data marks the end of a block.
// o_parity: n parity codewords per block, highest order first; last_parity on the final.
// i_cfg  : writes ec_count; n is ec_count held to 7..30 and to MAX_PARITY. Always ready.
// Throughput: one data codeword per cycle outside the stalls below, via a chain of
// MAX_PARITY cells, each holding one remainder byte, fed by one broadcast feedback byte.
// Latency: the first parity codeword is valid the cycle after the last data codeword.
// Parity is shifted out of a second line of the cells, so the next block is taken
// while the previous parity drains; a block's last codeword waits only until the
// previous parity line has been emptied (or empties in that same cycle).
// Reset and every ec_count write: clear the chain, then derive the generator one
// factor a cycle; i_data is not ready while the chain is cleared and derived.
// Receiver stall: parity holds in the shift line; data keeps flowing except the
// codeword that closes a block.
`default_nettype none

module qr_reed_solomon_ecc_encoder #(
    parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    rse_data_if.sink       i_data,
    rse_cfg_if.sink        i_cfg,
    rse_parity_if.source   o_parity
);

    localparam int CW = $clog2(MAX_PARITY + 1);

    rse_pkg::t_state     r_state;
    rse_pkg::t_state     n_state;
    rse_pkg::t_cell_ctrl w_ctrl;

    logic [rse_pkg::EC_WIDTH-1:0] r_ec;
    logic [CW-1:0]                r_step;
    logic [CW-1:0]                n_step;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                n_cnt;
    logic [7:0]                   r_root;
    logic [7:0]                   n_root;
    logic [CW-1:0]                w_eff_n;
    logic [rse_pkg::EC_WIDTH-1:0] w_sat;

    logic w_in_acc;
    logic w_out_acc;
    logic w_cfg_acc;
    logic w_out_free;
    logic w_load;

    logic [7:0] w_rem [MAX_PARITY];
    logic [7:0] w_gen [MAX_PARITY];
    logic [7:0] w_par [MAX_PARITY];

    // Effective parity count: saturate into the legal range, cap at the chain length
    always_comb begin
        w_sat = r_ec;
        if (int'(r_ec) < rse_pkg::EC_MIN) begin
            w_sat = rse_pkg::EC_WIDTH'(rse_pkg::EC_MIN);
        end else if (int'(r_ec) > rse_pkg::EC_MAX) begin
            w_sat = rse_pkg::EC_WIDTH'(rse_pkg::EC_MAX);
        end
        if (int'(w_sat) > MAX_PARITY) begin
            w_eff_n = CW'(MAX_PARITY);
        end else begin
            w_eff_n = CW'(w_sat);
        end
    end

    assign w_cfg_acc = i_cfg.valid && i_cfg.ready;
    assign w_in_acc  = i_data.valid && i_data.ready;
    assign w_out_acc = o_parity.valid && o_parity.ready;
    assign w_load    = w_in_acc && i_data.last_data;
    // Parity line can take a new block when empty or emptying now
    assign w_out_free = (r_cnt == '0) || ((r_cnt == CW'(1)) && o_parity.ready);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ec <= rse_pkg::EC_RESET;
        end else if (w_cfg_acc) begin
            r_ec <= i_cfg.ec_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::S_CLEAR;
            r_step  <= '0;
            r_cnt   <= '0;
            r_root  <= 8'h01;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_root  <= n_root;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_root         = r_root;
        n_cnt          = r_cnt;
        i_data.ready   = 1'b0;
        w_ctrl         = '0;
        w_ctrl.fb      = i_data.data_byte ^ w_rem[MAX_PARITY-1];
        w_ctrl.root    = r_root;
        case (r_state)
            rse_pkg::S_CLEAR: begin
                // Wipe remainder and generator, restart the factor sequence
                w_ctrl.clear = 1'b1;
                n_step       = '0;
                n_root       = 8'h01;
                n_cnt        = '0;
                n_state      = rse_pkg::S_DERIVE;
            end
            rse_pkg::S_DERIVE: begin
                w_ctrl.gen_step = 1'b1;
                n_root          = rse_pkg::gf_xtime(r_root);
                n_step          = r_step + CW'(1);
                if (r_step == w_eff_n - CW'(1)) begin
                    n_state = rse_pkg::S_RUN;
                end
            end
            rse_pkg::S_RUN: begin
                i_data.ready     = !i_data.last_data || w_out_free;
                w_ctrl.rem_step  = w_in_acc;
                w_ctrl.rem_zero  = i_data.last_data;
                w_ctrl.par_load  = w_load;
                w_ctrl.par_shift = w_out_acc;
                if (w_load) begin
                    n_cnt = w_eff_n;
                end else if (w_out_acc) begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            default: begin
                n_state = rse_pkg::S_CLEAR;
            end
        endcase
        // A register write restarts the block and rederives the generator
        if (w_cfg_acc) begin
            n_state = rse_pkg::S_CLEAR;
            n_cnt   = '0;
        end
    end

    // Cell j holds remainder byte j; the generator sits right-aligned at the top
    // of the chain, so the feedback always comes from the top cell.
    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        logic [7:0] w_rem_lo;
        logic [7:0] w_gen_hi;
        logic [7:0] w_par_lo;

        if (j == 0) begin : g_bottom
            assign w_rem_lo = 8'h00;
            assign w_par_lo = 8'h00;
        end else begin : g_inner_lo
            assign w_rem_lo = w_rem[j-1];
            assign w_par_lo = w_par[j-1];
        end

        if (j == MAX_PARITY - 1) begin : g_top
            // Monic leading term of the generator
            assign w_gen_hi = 8'h01;
        end else begin : g_inner_hi
            assign w_gen_hi = w_gen[j+1];
        end

        rse_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_rem_lo (w_rem_lo),
            .i_gen_hi (w_gen_hi),
            .i_par_lo (w_par_lo),
            .o_rem    (w_rem[j]),
            .o_gen    (w_gen[j]),
            .o_par    (w_par[j])
        );
    end

    assign o_parity.valid       = (r_cnt != '0);
    assign o_parity.parity_byte = w_par[MAX_PARITY-1];
    assign o_parity.last_parity = (r_cnt == CW'(1));

`ifndef ASSERT_OFF
    // Parity is only pending while the generator is in place
    a_idle_when_deriving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rse_pkg::S_RUN) |-> (r_cnt == '0))
        else $error("parity pending outside run state");

    // Closing a block loads exactly n parity codewords
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_cfg_acc) |=> (r_cnt == $past(w_eff_n)))
        else $error("parity count not loaded with n");

    // The shift line never claims more codewords than cells in use
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= w_eff_n))
        else $error("parity count exceeds n");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

    // Row kinds of the directed table: a data codeword, or a parity count write
    typedef enum logic {
        ROW_CODEWORD,
        ROW_EC_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] value;        // data codeword, or ec_count in the low five bits
        logic       last;         // closes the block (codeword rows only)
        logic       zero_parity;  // parity known to be all zero
    } t_stim_row;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       last_parity;
    } t_parity_word;

    localparam int CELLS         = rse_pkg::MAX_PARITY_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 200000;

    // Directed part, walked top to bottom. Reset leaves 10 parity codewords.
    // A message of all-zero codewords always gives all-zero parity, so those rows carry
    // their expectation; the rest are checked against the predictor.
    localparam int DIRECTED_ROWS = 25;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_CODEWORD, 8'h00, 1'b1, 1'b1},  // straight after reset
        '{ROW_CODEWORD, 8'hFF, 1'b1, 1'b0},
        '{ROW_CODEWORD, 8'h01, 1'b1, 1'b0},
        '{ROW_CODEWORD, 8'h80, 1'b0, 1'b0},
        '{ROW_CODEWORD, 8'h7F, 1'b0, 1'b0},
        '{ROW_CODEWORD, 8'h55, 1'b0, 1'b0},
        '{ROW_CODEWORD, 8'hAA, 1'b1, 1'b0},
        '{ROW_CODEWORD, 8'h12, 1'b0, 1'b0},  // block left open...
        '{ROW_CODEWORD, 8'h34, 1'b0, 1'b0},
        '{ROW_EC_WRITE, 8'h00, 1'b0, 1'b0},  // ...and dropped by the write; n saturates to 7
        '{ROW_CODEWORD, 8'h00, 1'b1, 1'b1},  // zero parity proves the chain was cleared
        '{ROW_CODEWORD, 8'hFF, 1'b0, 1'b0},
        '{ROW_CODEWORD, 8'h00, 1'b1, 1'b0},
        '{ROW_EC_WRITE, 8'h1F, 1'b0, 1'b0},  // all ones: n saturates to 30
        '{ROW_CODEWORD, 8'hA5, 1'b0, 1'b0},
        '{ROW_CODEWORD, 8'h5A, 1'b0, 1'b0},
        '{ROW_CODEWORD, 8'hFF, 1'b1, 1'b0},
        '{ROW_CODEWORD, 8'h00, 1'b0, 1'b0},
        '{ROW_CODEWORD, 8'h00, 1'b1, 1'b1},
        '{ROW_EC_WRITE, 8'h07, 1'b0, 1'b0},  // lowest legal count
        '{ROW_CODEWORD, 8'h3C, 1'b1, 1'b0},
        '{ROW_EC_WRITE, 8'h1E, 1'b0, 1'b0},  // highest legal count
        '{ROW_CODEWORD, 8'hC3, 1'b1, 1'b0},
        '{ROW_EC_WRITE, 8'h06, 1'b0, 1'b0},  // one below the range
        '{ROW_CODEWORD, 8'h81, 1'b1, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    rse_data_if   data_ch ();
    rse_cfg_if    cfg_ch ();
    rse_parity_if parity_ch ();

    qr_reed_solomon_ecc_encoder dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_data   (data_ch),
        .i_cfg    (cfg_ch),
        .o_parity (parity_ch)
    );

    // 2 ns period
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: the configured count, the effective parity length, the
    // low-order generator terms and the LFSR cells holding the running remainder
    logic [4:0]   ec_reg;
    int           n_par;
    logic [7:0]   gen_poly [CELLS];
    logic [7:0]   lfsr_cell [CELLS];
    t_parity_word parity_due [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int codewords_sent = 0;
    int blocks_closed  = 0;
    int parity_checked = 0;
    int cfg_writes     = 0;
    int cycle_count    = 0;
    t_parity_word head_word;

    // GF(256) product, Horner form over the bits of b, most significant first
    function automatic logic [7:0] gf256_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        int i;
        acc = 8'h00;
        for (i = 7; i >= 0; i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? rse_pkg::GF_POLY_LO : 8'h00);
            if (b[i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // Parity length actually used: clamp into the legal range and the chain size
    function automatic int parity_len(input logic [4:0] v);
        int k;
        k = v;
        if (k < rse_pkg::EC_MIN) begin
            k = rse_pkg::EC_MIN;
        end
        if (k > rse_pkg::EC_MAX) begin
            k = rse_pkg::EC_MAX;
        end
        if (k > CELLS) begin
            k = CELLS;
        end
        return k;
    endfunction

    // Take a new count: expand the product of (x + alpha^i), i < n, and clear the cells
    task automatic load_ec_count(input logic [4:0] v);
        logic [7:0] c [CELLS+1];
        logic [7:0] root;
        int i;
        int k;
        ec_reg = v;
        n_par  = parity_len(v);
        for (k = 0; k <= CELLS; k++) begin
            c[k] = 8'h00;
        end
        c[0] = 8'h01;
        root = 8'h01;
        for (i = 0; i < n_par; i++) begin
            for (k = i + 1; k > 0; k--) begin
                c[k] = c[k-1] ^ gf256_times(c[k], root);
            end
            c[0] = gf256_times(c[0], root);
            root = gf256_times(root, 8'h02);
        end
        for (k = 0; k < CELLS; k++) begin
            gen_poly[k]  = (k < n_par) ? c[k] : 8'h00;
            lfsr_cell[k] = 8'h00;
        end
    endtask

    // Shift one codeword into the remainder; on the block's last codeword queue the
    // n parity codewords, highest order first, and clear the cells
    task automatic absorb_codeword(input logic [7:0] d, input logic last,
                                   input logic zero_parity);
        logic [7:0] fb;
        t_parity_word w;
        int j;
        fb = d ^ lfsr_cell[n_par-1];
        for (j = n_par - 1; j > 0; j--) begin
            lfsr_cell[j] = lfsr_cell[j-1] ^ gf256_times(fb, gen_poly[j]);
        end
        lfsr_cell[0] = gf256_times(fb, gen_poly[0]);
        if (last) begin
            for (j = 0; j < n_par; j++) begin
                w.parity_byte = zero_parity ? 8'h00 : lfsr_cell[n_par-1-j];
                w.last_parity = (j == n_par - 1);
                parity_due.insert(parity_due.size(), w);
            end
            for (j = 0; j < CELLS; j++) begin
                lfsr_cell[j] = 8'h00;
            end
            blocks_closed++;
        end
    endtask

    // Offer one codeword, with random idle cycles first, and hold it until the
    // transaction completes. Valid stays high into the next codeword unless idling.
    task automatic send_codeword(input logic [7:0] d, input logic last,
                                 input logic zero_parity);
        while ($urandom_range(99) < src_idle_pct) begin
            data_ch.valid <= 1'b0;
            @(posedge clk);
        end
        data_ch.valid     <= 1'b1;
        data_ch.data_byte <= d;
        data_ch.last_data <= last;
        @(posedge clk);
        while (!data_ch.ready) begin
            @(posedge clk);
        end
        absorb_codeword(d, last, zero_parity);
        codewords_sent++;
    endtask

    // Drop valid and hold off until every queued parity codeword has arrived
    task automatic drain_parity();
        data_ch.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (parity_due.size() != 0);
    endtask

    // Write ec_count with the block idle. A block left open has no parity to wait
    // for, so let the chain settle before the write.
    task automatic write_ec_count(input logic [4:0] v);
        drain_parity();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.ec_count <= v;
        @(posedge clk);
        while (!cfg_ch.ready) begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        load_ec_count(v);
        cfg_writes++;
    endtask

    // One random phase: blocks of random length and content, mostly short, now and
    // then long, all-zero or all-ones. The budget may cut the final block short,
    // leaving it for the next write to drop. After the second block the sender
    // pauses until the parity line has drained.
    task automatic run_random_phase(input int src_pct, input int snk_pct,
                                    input logic [4:0] ec, input int budget);
        int sent;
        int len;
        int k;
        int flavour;
        int nblk;
        logic [7:0] d;
        write_ec_count(ec);
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        sent = 0;
        nblk = 0;
        while (sent < budget) begin
            len     = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            flavour = $urandom_range(9);
            for (k = 0; k < len && sent < budget; k++) begin
                case (flavour)
                    0: begin
                        d = 8'h00;
                    end
                    1: begin
                        d = 8'hFF;
                    end
                    default: begin
                        d = $urandom_range(255);
                    end
                endcase
                send_codeword(d, k == len - 1, 1'b0);
                sent++;
            end
            nblk++;
            if (nblk == 2) begin
                drain_parity();
            end
        end
    endtask

    // Parity monitor and receiver: check the transaction that completes at this
    // edge against the oldest expectation, then pick the ready for the next cycle
    always @(posedge clk) begin
        if (rst_n && parity_ch.valid && parity_ch.ready) begin
            if (parity_due.size() == 0) begin
                $error("parity transaction with nothing expected: parity_byte %02h last_parity %0b",
                       parity_ch.parity_byte, parity_ch.last_parity);
                mismatches++;
            end else begin
                head_word = parity_due.pop_front();
                if (parity_ch.parity_byte !== head_word.parity_byte) begin
                    $error("parity_byte: expected %02h, got %02h",
                           head_word.parity_byte, parity_ch.parity_byte);
                    mismatches++;
                end
                if (parity_ch.last_parity !== head_word.last_parity) begin
                    $error("last_parity: expected %0b, got %0b",
                           head_word.last_parity, parity_ch.last_parity);
                    mismatches++;
                end
                parity_checked++;
            end
        end
        parity_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d parity codewords outstanding",
                     cycle_count, parity_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int r;
        t_stim_row row;

        // Every input known from time zero; hold reset, then release it
        rst_n             <= 1'b0;
        data_ch.valid     <= 1'b0;
        data_ch.data_byte <= 8'h00;
        data_ch.last_data <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.ec_count   <= 5'd0;
        load_ec_count(rse_pkg::EC_RESET);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling on either side
        for (r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_EC_WRITE) begin
                write_ec_count(row.value[4:0]);
            end else begin
                send_codeword(row.value, row.last, row.zero_parity);
            end
        end

        // Random phases: no idling, sender idle, receiver stalling, both, then none
        // again at a random count
        run_random_phase(0, 0, 5'd31, 30);
        run_random_phase(55, 0, 5'd0, 30);
        run_random_phase(0, 55, 5'd30, 30);
        run_random_phase(15, 15, 5'd7, 30);
        run_random_phase(0, 0, 5'($urandom_range(31)), 30);

        // Drain, then let any stray output show itself
        drain_parity();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d data codewords in %0d closed blocks, %0d parity codewords checked",
                 codewords_sent, blocks_closed, parity_checked);
        $display("%0d parity count writes (7 to 30 codewords, out-of-range values too), %0d cycles",
                 cfg_writes, cycle_count);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
